>>> design/pwst_pkg.sv
// ----------------------------------------------------------------------------
// Perturbed wave sum texture package
// Shared constants, types, the quarter-wave sine table and its lookup.
// ----------------------------------------------------------------------------
package pwst_pkg;

  localparam int MAX_WAVES       = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SLOT_W          = $clog2(MAX_WAVES);
  localparam int COUNT_W         = $clog2(MAX_WAVES + 1);
  localparam int QTR_W           = SINE_TABLE_BITS - 2;
  localparam int QUARTER         = 1 << QTR_W;

  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598668;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172272;
  localparam int              ATTEN_Q16 = 26214;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE_WAVES = 1'b0;
  localparam logic CFG_SQUASH_SCALE = 1'b1;

  // Item operations.
  localparam logic OP_EVALUATE = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  typedef logic [16:0]   sine_mag_t;
  typedef sine_mag_t     sine_tab_t [QUARTER];

  typedef struct packed {
    logic signed [32:0] a;
    logic signed [25:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [48:0] rad;
    logic [24:0] mag;
  } rd_req_t;

  typedef struct packed {
    logic        done;
    logic [17:0] quot;
  } rd_rsp_t;

  // Quarter-wave magnitudes from the odd polynomial, evaluated at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned m;
    for (int i = 0; i < QUARTER; i++) begin
      t  = longint'(i) << (32 - SINE_TABLE_BITS);
      t2 = (t * t) >> 30;
      p  = SIN_C9;
      p  = SIN_C7 - ((p * t2) >> 30);
      p  = SIN_C5 - ((p * t2) >> 30);
      p  = SIN_C3 - ((p * t2) >> 30);
      p  = SIN_C1 - ((p * t2) >> 30);
      s  = (p * t) >> 30;
      m  = (s + 64'd8192) >> 14;
      if (m > 64'd65536) m = 64'd65536;
      tab[i] = sine_mag_t'(m);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Sine of the angle idx / 2^SINE_TABLE_BITS of a full turn, Q16.
  function automatic logic signed [17:0] sine_q16(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]     quad;
    logic [QTR_W:0] f;
    sine_mag_t      mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    f    = {1'b0, idx[QTR_W-1:0]};
    if (quad[0]) f = (QTR_W + 1)'(QUARTER) - f;
    if (f[QTR_W]) mag = 17'd65536;
    else mag = SINE_TAB[f[QTR_W-1:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

>>> design/pwst_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one evaluate or load transaction.
// ----------------------------------------------------------------------------
interface pwst_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         wave_slot;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [17:0] wave_amplitude;
  logic signed [23:0] freq_x;
  logic signed [23:0] freq_y;
  logic [15:0]        wave_phase;

  modport source (output valid, operation, wave_slot, x_coord, y_coord, wave_amplitude,
                  freq_x, freq_y, wave_phase, input ready);
  modport sink (input valid, operation, wave_slot, x_coord, y_coord, wave_amplitude,
                freq_x, freq_y, wave_phase, output ready);
endinterface

>>> design/pwst_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one texture value transaction.
// ----------------------------------------------------------------------------
interface pwst_result_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] texture_value;
  logic               clipped;

  modport source (output valid, texture_value, clipped, input ready);
  modport sink (input valid, texture_value, clipped, output ready);
endinterface

>>> design/perturbed_wave_sum_texture.sv
// ----------------------------------------------------------------------------
// Perturbed wave sum texture
// Sequencer, wave table and accumulator around one shared multiplier.
// ----------------------------------------------------------------------------
// A load transaction writes one wave table entry and gives no result. An
// evaluate transaction with N active waves makes seven passes per wave
// through the one shared multiplier, and when squashing is enabled it also
// runs the bit-serial square root (31 steps) and division (18 steps). The
// block takes no new transaction while an evaluation runs; the result waits
// in an output register, and a finished evaluation holds until that
// register is free.
module perturbed_wave_sum_texture (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  pwst_item_if.sink   point,
  pwst_result_if.source texture
);

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_UX   = 18'h00002,
    ST_UY   = 18'h00004,
    ST_VX   = 18'h00008,
    ST_VY   = 18'h00010,
    ST_VSUM = 18'h00020,
    ST_ATT  = 18'h00040,
    ST_GAIN = 18'h00080,
    ST_RMUL = 18'h00100,
    ST_WADD = 18'h00200,
    ST_AMP  = 18'h00400,
    ST_ACC  = 18'h00800,
    ST_SUM  = 18'h01000,
    ST_SQ1  = 18'h02000,
    ST_SQ2  = 18'h04000,
    ST_SQ3  = 18'h08000,
    ST_ROOT = 18'h10000,
    ST_DONE = 18'h20000
  } state_t;

  localparam int B = pwst_pkg::SINE_TABLE_BITS;

  state_t state;

  logic [4:0]  active_waves;
  logic [23:0] squash_scale;

  logic signed [17:0] amp_tab   [pwst_pkg::MAX_WAVES];
  logic signed [23:0] freqx_tab [pwst_pkg::MAX_WAVES];
  logic signed [23:0] freqy_tab [pwst_pkg::MAX_WAVES];
  logic [15:0]        phase_tab [pwst_pkg::MAX_WAVES];

  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic [pwst_pkg::COUNT_W-1:0] k;
  logic [pwst_pkg::COUNT_W-1:0] n_r;
  logic [39:0]        acc_u;
  logic [39:0]        u;
  logic [39:0]        tv;
  logic [39:0]        v;
  logic signed [17:0] g;
  logic [37:0]        w;
  logic signed [39:0] acc;
  logic signed [24:0] s_r;
  logic               clip_r;
  logic [48:0]        d1;
  logic signed [24:0] res_r;

  logic signed [24:0] out_value;
  logic               out_clip;
  logic               out_valid;

  pwst_pkg::mul_req_t mreq;
  logic signed [58:0] prod;
  pwst_pkg::rd_req_t  rdreq;
  pwst_pkg::rd_rsp_t  rdrsp;

  logic signed [23:0] fx;
  logic signed [23:0] fy;
  logic [B-1:0]       idx_u;
  logic [B-1:0]       idx_v;
  logic [B-1:0]       idx_c;
  logic signed [17:0] s1;
  logic signed [17:0] s2;
  logic signed [17:0] cw;
  logic signed [58:0] gsum;
  logic signed [58:0] rsum;
  logic signed [39:0] sum_full;
  logic [24:0]        mag;
  logic [24:0]        qext;
  logic               accept;
  logic               out_free;

  pwst_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  pwst_root_div u_root_div (
    .clk (clk),
    .rst (rst),
    .req (rdreq),
    .rsp (rdrsp)
  );

  assign fx = freqx_tab[k[pwst_pkg::SLOT_W-1:0]];
  assign fy = freqy_tab[k[pwst_pkg::SLOT_W-1:0]];

  // Angle fractions rounded to the table resolution, ties up.
  assign idx_u = u[39 -: B] + {{(B-1){1'b0}}, u[39-B]};
  assign idx_v = v[39 -: B] + {{(B-1){1'b0}}, v[39-B]};
  assign idx_c = w[37 -: B] + {{(B-1){1'b0}}, w[37-B]} + B'(pwst_pkg::QUARTER);

  assign s1 = pwst_pkg::sine_q16(idx_u);
  assign s2 = pwst_pkg::sine_q16(idx_v);
  assign cw = pwst_pkg::sine_q16(idx_c);

  assign gsum     = prod + 59'sd32768;
  assign rsum     = prod + 59'sd131072;
  assign sum_full = (acc + 40'sd32768) >>> 16;
  assign mag      = s_r[24] ? 25'(-s_r) : s_r;
  assign qext     = {7'd0, rdrsp.quot};

  assign accept   = point.valid && point.ready;
  assign out_free = !out_valid || texture.ready;

  always_comb begin
    mreq = '0;
    unique case (state)
      ST_UX:   begin mreq.a = {x_r[31], x_r}; mreq.b = {{2{fy[23]}}, fy}; end
      ST_UY:   begin mreq.a = {y_r[31], y_r}; mreq.b = {{2{fx[23]}}, fx}; end
      ST_VX:   begin mreq.a = {x_r[31], x_r}; mreq.b = {{2{fx[23]}}, fx}; end
      ST_VY:   begin mreq.a = {y_r[31], y_r}; mreq.b = {{2{fy[23]}}, fy}; end
      ST_ATT:  begin
        mreq.a = 33'(pwst_pkg::ATTEN_Q16);
        mreq.b = {{8{s2[17]}}, s2};
      end
      ST_RMUL: begin mreq.a = {{15{s1[17]}}, s1}; mreq.b = {{8{g[17]}}, g}; end
      ST_AMP:  begin
        mreq.a = {{15{cw[17]}}, cw};
        mreq.b = {{8{amp_tab[k[pwst_pkg::SLOT_W-1:0]][17]}},
                  amp_tab[k[pwst_pkg::SLOT_W-1:0]]};
      end
      ST_SQ1:  begin mreq.a = {9'd0, squash_scale}; mreq.b = {2'b00, squash_scale}; end
      ST_SQ2:  begin mreq.a = {8'd0, mag}; mreq.b = {1'b0, mag}; end
      default: mreq = '0;
    endcase
  end

  always_comb begin
    rdreq.start = (state == ST_SQ3);
    rdreq.rad   = d1 + prod[48:0];
    rdreq.mag   = mag;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_waves <= '0;
      squash_scale <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pwst_pkg::CFG_ACTIVE_WAVES: active_waves <= cfg_data[4:0];
        pwst_pkg::CFG_SQUASH_SCALE: squash_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Wave table.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pwst_pkg::MAX_WAVES; i++) begin
        amp_tab[i]   <= '0;
        freqx_tab[i] <= '0;
        freqy_tab[i] <= '0;
        phase_tab[i] <= '0;
      end
    end else if (accept && point.operation == pwst_pkg::OP_LOAD &&
                 32'(point.wave_slot) < pwst_pkg::MAX_WAVES) begin
      amp_tab[pwst_pkg::SLOT_W'(point.wave_slot)]   <= point.wave_amplitude;
      freqx_tab[pwst_pkg::SLOT_W'(point.wave_slot)] <= point.freq_x;
      freqy_tab[pwst_pkg::SLOT_W'(point.wave_slot)] <= point.freq_y;
      phase_tab[pwst_pkg::SLOT_W'(point.wave_slot)] <= point.wave_phase;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (texture.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && point.operation == pwst_pkg::OP_EVALUATE) begin
            x_r <= point.x_coord;
            y_r <= point.y_coord;
            k   <= '0;
            acc <= '0;
            if (32'(active_waves) > pwst_pkg::MAX_WAVES) begin
              n_r   <= pwst_pkg::COUNT_W'(pwst_pkg::MAX_WAVES);
              state <= ST_UX;
            end else begin
              n_r   <= pwst_pkg::COUNT_W'(active_waves);
              state <= (active_waves == 5'd0) ? ST_SUM : ST_UX;
            end
          end
        end
        ST_UX:   state <= ST_UY;
        ST_UY: begin
          acc_u <= prod[39:0];
          state <= ST_VX;
        end
        ST_VX: begin
          u     <= acc_u - prod[39:0];
          state <= ST_VY;
        end
        ST_VY: begin
          tv    <= prod[39:0];
          state <= ST_VSUM;
        end
        ST_VSUM: begin
          v     <= tv + prod[39:0];
          state <= ST_ATT;
        end
        ST_ATT:  state <= ST_GAIN;
        ST_GAIN: begin
          g     <= 18'sd65536 + $signed(gsum[33:16]);
          state <= ST_RMUL;
        end
        ST_RMUL: state <= ST_WADD;
        ST_WADD: begin
          // Only the low 16 bits of the perturbation survive the cycle wrap.
          w     <= v[37:0] + {phase_tab[k[pwst_pkg::SLOT_W-1:0]], 22'd0}
                   + {rsum[33:18], 22'd0};
          state <= ST_AMP;
        end
        ST_AMP:  state <= ST_ACC;
        ST_ACC: begin
          acc <= acc + $signed(prod[39:0]);
          k   <= k + 1'b1;
          state <= (k + 1'b1 == n_r) ? ST_SUM : ST_UX;
        end
        ST_SUM: begin
          if (sum_full > 40'sd16777215) begin
            s_r    <= 25'sh0FFFFFF;
            clip_r <= 1'b1;
          end else if (sum_full < -40'sd16777216) begin
            s_r    <= 25'sh1000000;
            clip_r <= 1'b1;
          end else begin
            s_r    <= sum_full[24:0];
            clip_r <= 1'b0;
          end
          state <= (squash_scale == 24'd0) ? ST_DONE : ST_SQ1;
        end
        ST_SQ1: begin
          clip_r <= 1'b0;
          res_r  <= s_r;
          state  <= ST_SQ2;
        end
        ST_SQ2: begin
          d1    <= prod[48:0];
          state <= ST_SQ3;
        end
        ST_SQ3:  state <= ST_ROOT;
        ST_ROOT: begin
          if (rdrsp.done) begin
            s_r   <= res_r[24] ? 25'(-qext) : qext;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_value <= s_r;
            out_clip  <= clip_r;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign point.ready           = (state == ST_IDLE);
  assign texture.valid         = out_valid;
  assign texture.texture_value = out_value;
  assign texture.clipped       = out_clip;

endmodule

>>> design/pwst_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 33 x 26 multiplier with a registered product, reused every cycle.
// ----------------------------------------------------------------------------
module pwst_mul (
  input  logic               clk,
  input  pwst_pkg::mul_req_t req,
  output logic signed [58:0] prod
);

  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
  end

endmodule

>>> design/pwst_root_div.sv
// ----------------------------------------------------------------------------
// Squash root and divide unit
// Floor square root of rad*4096, two bits a cycle, then a rounded
// restoring division of mag*2^22 by that root, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pwst_root_div (
  input  logic              clk,
  input  logic              rst,
  input  pwst_pkg::rd_req_t req,
  output pwst_pkg::rd_rsp_t rsp
);

  typedef enum logic [3:0] {
    RD_IDLE = 4'b0001,
    RD_ROOT = 4'b0010,
    RD_PREP = 4'b0100,
    RD_DIV  = 4'b1000
  } rd_state_t;

  rd_state_t   state;
  logic [61:0] rad_sh;
  logic [32:0] rem;
  logic [30:0] root;
  logic [4:0]  cnt;
  logic [30:0] rmd;
  logic [17:0] numlo;
  logic [17:0] quot;
  logic [24:0] mag_r;
  logic        done;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [47:0] num;
  logic [31:0] dtry;

  assign rem_sh = {rem, rad_sh[61:60]};
  assign trial  = {2'b00, root, 2'b01};
  assign num    = {1'b0, mag_r, 22'd0} + {18'd0, root[30:1]};
  assign dtry   = {rmd, numlo[17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        RD_IDLE: begin
          if (req.start) begin
            rad_sh <= {1'b0, req.rad, 12'd0};
            rem    <= '0;
            root   <= '0;
            cnt    <= 5'd30;
            mag_r  <= req.mag;
            state  <= RD_ROOT;
          end
        end
        RD_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= 33'(rem_sh - trial);
            root <= {root[29:0], 1'b1};
          end else begin
            rem  <= rem_sh[32:0];
            root <= {root[29:0], 1'b0};
          end
          rad_sh <= {rad_sh[59:0], 2'b00};
          cnt    <= cnt - 5'd1;
          if (cnt == 5'd0) state <= RD_PREP;
        end
        RD_PREP: begin
          // The quotient stays below 2^18, so the top bits already sit below the root.
          rmd   <= {1'b0, num[47:18]};
          numlo <= num[17:0];
          quot  <= '0;
          cnt   <= 5'd17;
          state <= RD_DIV;
        end
        RD_DIV: begin
          if (dtry >= {1'b0, root}) begin
            rmd  <= 31'(dtry - {1'b0, root});
            quot <= {quot[16:0], 1'b1};
          end else begin
            rmd  <= dtry[30:0];
            quot <= {quot[16:0], 1'b0};
          end
          numlo <= {numlo[16:0], 1'b0};
          cnt   <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            done  <= 1'b1;
            state <= RD_IDLE;
          end
        end
        default: state <= RD_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
